### rtl/core/tkh_pkg.sv
// Shared types and constants for the top-k smallest heap core.
`default_nettype none

package tkh_pkg;

   // Heap geometry and field widths.
   localparam int HEAP_DEPTH = 64;
   localparam int IDX_W      = $clog2(HEAP_DEPTH);
   localparam int CNT_W      = IDX_W + 1;
   localparam int KEY_W      = 32;
   localparam int PAY_W      = 64;

   // Keep count after reset: the whole heap.
   localparam logic [CNT_W-1:0] KEEP_RESET = CNT_W'(HEAP_DEPTH);

   // One heap entry: the ordering key and the row stored with it.
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } entry_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_UP_READ,
      ST_UP_CMP,
      ST_DN_READ,
      ST_DN_CMP,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;     // capture the accepted item
      logic start_fill;    // append at the end of the heap, bump the count
      logic start_replace; // evict the root, new item enters at the root
      logic start_reject;  // the new item itself is discarded
      logic rd_parent;     // read port 0 fetches the parent instead of the left child
      logic wr_cur;        // write the held item at the current slot
      logic mv_up;         // move the parent down into the current slot
      logic mv_down;       // move the larger child up into the current slot
      logic load_out;      // load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic fill;          // heap is below the keep count
      logic less_root;     // new key is strictly below the root key
      logic at_root;       // current slot is the root
      logic parent_less;   // parent key is below the held key
      logic down_leaf;     // current slot has no child inside the heap
      logic child_wins;    // held key is below the larger child key
      logic out_free;      // result register can take a new item
   } status_type;

endpackage : tkh_pkg

`default_nettype wire

### rtl/core/top_k_smallest_heap_core.sv
// Top level of the top-k smallest heap core: controller plus datapath.
// One item at a time: a rejected row goes from acceptance through a start step to its result;
// a fill or replace walks the heap level by level, each level a memory read, then a compare
// and write, and the result register is loaded once the walk ends.
// A result register lets the next item be accepted while a result waits.
// Reset clears the held count and sets keep_count to 64; heap memory is not cleared.
`default_nettype none

module top_k_smallest_heap_core (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write_enable,
   input  wire logic [tkh_pkg::CNT_W-1:0] csr_write_data,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [tkh_pkg::KEY_W-1:0] req_sort_key,
   input  wire logic [tkh_pkg::PAY_W-1:0] req_row_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [tkh_pkg::CNT_W-1:0]      rsp_held_count,
   output logic                           rsp_was_discarded,
   output logic [tkh_pkg::KEY_W-1:0]      rsp_discarded_key,
   output logic [tkh_pkg::PAY_W-1:0]      rsp_discarded_payload,
   output logic [tkh_pkg::KEY_W-1:0]      rsp_largest_kept_key
);
   import tkh_pkg::*;

   cmd_type    cmd;
   status_type sts;

   // Sequencer.
   tkh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Heap storage and result path.
   tkh_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .req_sort_key          (req_sort_key),
      .req_row_payload       (req_row_payload),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_held_count        (rsp_held_count),
      .rsp_was_discarded     (rsp_was_discarded),
      .rsp_discarded_key     (rsp_discarded_key),
      .rsp_discarded_payload (rsp_discarded_payload),
      .rsp_largest_kept_key  (rsp_largest_kept_key)
   );

endmodule : top_k_smallest_heap_core

`default_nettype wire

### rtl/core/tkh_ctrl.sv
// Controller state machine for the top-k smallest heap core.
`default_nettype none

module tkh_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire tkh_pkg::status_type sts,
   output tkh_pkg::cmd_type        cmd
);
   import tkh_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (sts.fill) begin
               state_in = ST_UP_READ;
            end else if (sts.less_root) begin
               state_in = ST_DN_READ;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_UP_READ: begin
            state_in = sts.at_root ? ST_DONE : ST_UP_CMP;
         end
         ST_UP_CMP: begin
            state_in = sts.parent_less ? ST_UP_READ : ST_DONE;
         end
         ST_DN_READ: begin
            state_in = sts.down_leaf ? ST_DONE : ST_DN_CMP;
         end
         ST_DN_CMP: begin
            state_in = sts.child_wins ? ST_DN_READ : ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         ST_START: begin
            cmd.start_fill    = sts.fill;
            cmd.start_replace = !sts.fill && sts.less_root;
            cmd.start_reject  = !sts.fill && !sts.less_root;
         end
         ST_UP_READ: begin
            cmd.rd_parent = 1'b1;
            cmd.wr_cur    = sts.at_root;
         end
         ST_UP_CMP: begin
            cmd.mv_up  = sts.parent_less;
            cmd.wr_cur = !sts.parent_less;
         end
         ST_DN_READ: begin
            cmd.wr_cur = sts.down_leaf;
         end
         ST_DN_CMP: begin
            cmd.mv_down = sts.child_wins;
            cmd.wr_cur  = !sts.child_wins;
         end
         ST_DONE: begin
            cmd.load_out = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule : tkh_ctrl

`default_nettype wire

### rtl/core/tkh_datapath.sv
// Datapath for the top-k smallest heap core: heap memory, count, result register.
`default_nettype none

module tkh_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire tkh_pkg::cmd_type            cmd,
   output tkh_pkg::status_type              sts,
   input  wire logic                        csr_write_enable,
   input  wire logic [tkh_pkg::CNT_W-1:0]   csr_write_data,
   input  wire logic [tkh_pkg::KEY_W-1:0]   req_sort_key,
   input  wire logic [tkh_pkg::PAY_W-1:0]   req_row_payload,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [tkh_pkg::CNT_W-1:0]        rsp_held_count,
   output logic                             rsp_was_discarded,
   output logic [tkh_pkg::KEY_W-1:0]        rsp_discarded_key,
   output logic [tkh_pkg::PAY_W-1:0]        rsp_discarded_payload,
   output logic [tkh_pkg::KEY_W-1:0]        rsp_largest_kept_key
);
   import tkh_pkg::*;

   // Heap storage and read data.
   entry_type heap_mem_ff [HEAP_DEPTH];
   entry_type rd0_ff;
   entry_type rd1_ff;

   // Control and working registers.
   logic [CNT_W-1:0] keep_ff;
   logic [CNT_W-1:0] count_ff;
   logic [IDX_W-1:0] pos_ff;
   logic [IDX_W-1:0] pos_in;
   entry_type        cur_ff;
   entry_type        root_ff;
   entry_type        disc_ff;
   logic             disc_flag_ff;

   // Result register.
   logic             rsp_valid_ff;
   logic [CNT_W-1:0] rsp_count_ff;
   logic             rsp_flag_ff;
   entry_type        rsp_disc_ff;
   logic [KEY_W-1:0] rsp_max_ff;

   logic [CNT_W-1:0] keep_eff;
   logic [IDX_W-1:0] parent_idx;
   logic [CNT_W-1:0] left_idx;
   logic [CNT_W:0]   right_idx;
   logic             has_right;
   logic             pick_right;
   entry_type        child;
   logic [IDX_W-1:0] child_idx;
   logic [IDX_W-1:0] rd_addr0;
   logic             wr_en;
   entry_type        wr_data;

   // Effective keep count: zero acts as one, large values saturate at the depth.
   always_comb begin
      keep_eff = keep_ff;
      if (keep_ff == '0) begin
         keep_eff = CNT_W'(1);
      end else if (keep_ff > KEEP_RESET) begin
         keep_eff = KEEP_RESET;
      end
   end

   // Neighbor slots of the current position.
   assign parent_idx = IDX_W'((pos_ff - IDX_W'(1)) >> 1);
   assign left_idx   = {pos_ff, 1'b1};
   assign right_idx  = {1'b0, left_idx} + (CNT_W+1)'(1);
   assign has_right  = right_idx < {1'b0, count_ff};
   assign pick_right = has_right && (rd0_ff.key < rd1_ff.key);
   assign child      = pick_right ? rd1_ff : rd0_ff;
   assign child_idx  = pick_right ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];
   assign rd_addr0   = cmd.rd_parent ? parent_idx : left_idx[IDX_W-1:0];

   // Status to the controller.
   always_comb begin
      sts.fill        = count_ff < keep_eff;
      sts.less_root   = cur_ff.key < root_ff.key;
      sts.at_root     = pos_ff == '0;
      sts.parent_less = rd0_ff.key < cur_ff.key;
      sts.down_leaf   = left_idx >= count_ff;
      sts.child_wins  = cur_ff.key < child.key;
      sts.out_free    = !rsp_valid_ff || rsp_ready;
   end

   // Write port: the held item or an entry moving along the path.
   assign wr_en = cmd.wr_cur || cmd.mv_up || cmd.mv_down;
   always_comb begin
      wr_data = cur_ff;
      if (cmd.mv_up) begin
         wr_data = rd0_ff;
      end else if (cmd.mv_down) begin
         wr_data = child;
      end
   end

   // Heap memory: one write port, two registered read ports.
   // Port 0 reads the parent on the way up and the left child on the way down.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem_ff[pos_ff] <= wr_data;
      end
      rd0_ff <= heap_mem_ff[rd_addr0];
      rd1_ff <= heap_mem_ff[right_idx[IDX_W-1:0]];
   end

   // Current slot of the walk.
   always_comb begin
      pos_in = pos_ff;
      if (cmd.start_fill) begin
         pos_in = count_ff[IDX_W-1:0];
      end else if (cmd.start_replace) begin
         pos_in = '0;
      end else if (cmd.mv_up) begin
         pos_in = parent_idx;
      end else if (cmd.mv_down) begin
         pos_in = child_idx;
      end
   end

   // Control state: keep count and held count.
   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff  <= KEEP_RESET;
         count_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            keep_ff <= csr_write_data;
         end
         if (cmd.start_fill) begin
            count_ff <= count_ff + CNT_W'(1);
         end
      end
   end

   // Working registers: item, position, root copy and discarded row.
   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (cmd.load_item) begin
         cur_ff.key     <= req_sort_key;
         cur_ff.payload <= req_row_payload;
      end
      if (wr_en && (pos_ff == '0)) begin
         root_ff <= wr_data;
      end
      if (cmd.start_fill) begin
         disc_ff      <= '0;
         disc_flag_ff <= 1'b0;
      end else if (cmd.start_replace) begin
         disc_ff      <= root_ff;
         disc_flag_ff <= 1'b1;
      end else if (cmd.start_reject) begin
         disc_ff      <= cur_ff;
         disc_flag_ff <= 1'b1;
      end
   end

   // Result register valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_count_ff <= count_ff;
         rsp_flag_ff  <= disc_flag_ff;
         rsp_disc_ff  <= disc_ff;
         rsp_max_ff   <= root_ff.key;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_held_count        = rsp_count_ff;
   assign rsp_was_discarded     = rsp_flag_ff;
   assign rsp_discarded_key     = rsp_disc_ff.key;
   assign rsp_discarded_payload = rsp_disc_ff.payload;
   assign rsp_largest_kept_key  = rsp_max_ff;

endmodule : tkh_datapath

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the top-k smallest heap core, with its scoreboard package.

package top_k_check_pkg;
   import tkh_pkg::*;

   // Fields of one result item, in port order.
   typedef struct packed {
      logic [CNT_W-1:0] held_count;
      logic             was_discarded;
      logic [KEY_W-1:0] discarded_key;
      logic [PAY_W-1:0] discarded_payload;
      logic [KEY_W-1:0] largest_kept_key;
   } outcome_type;

   // Mirror of the kept rows; predicts one outcome per accepted row.
   class kept_rows_scoreboard;
      logic [CNT_W-1:0] keep_count;
      int unsigned      held;
      logic [KEY_W-1:0] keys [HEAP_DEPTH];
      logic [PAY_W-1:0] payloads [HEAP_DEPTH];
      outcome_type      expected_outcomes [$];
      int unsigned      mismatches;

      function new();
         keep_count = KEEP_RESET;
         held       = 0;
         mismatches = 0;
      endfunction

      function void set_keep(logic [CNT_W-1:0] value);
         keep_count = value;
      endfunction

      function int unsigned pending();
         return expected_outcomes.size();
      endfunction

      function void swap_slots(int unsigned a, int unsigned b);
         logic [KEY_W-1:0] k;
         logic [PAY_W-1:0] p;
         k           = keys[a];
         p           = payloads[a];
         keys[a]     = keys[b];
         payloads[a] = payloads[b];
         keys[b]     = k;
         payloads[b] = p;
      endfunction

      // Apply one accepted row to the mirrored heap and queue its outcome.
      function void note_row(logic [KEY_W-1:0] key, logic [PAY_W-1:0] payload);
         outcome_type result;
         int unsigned limit;
         int unsigned pos;
         int unsigned child;
         bit          moving;
         // A keep count of zero acts as one; anything above the depth saturates.
         limit = keep_count;
         if (limit == 0) limit = 1;
         if (limit > HEAP_DEPTH) limit = HEAP_DEPTH;
         result = '0;
         if (held < limit) begin
            // Append at the end and sift up while the parent key is smaller.
            keys[held]     = key;
            payloads[held] = payload;
            pos = held;
            while (pos > 0 && keys[(pos - 1) / 2] < keys[pos]) begin
               swap_slots((pos - 1) / 2, pos);
               pos = (pos - 1) / 2;
            end
            held++;
         end else if (key < keys[0]) begin
            // Evict the root, put the new row there and sift it down.
            result.was_discarded     = 1'b1;
            result.discarded_key     = keys[0];
            result.discarded_payload = payloads[0];
            keys[0]     = key;
            payloads[0] = payload;
            pos    = 0;
            moving = 1'b1;
            while (moving) begin
               child = 2 * pos + 1;
               if (child >= held) begin
                  moving = 1'b0;
               end else begin
                  if (child + 1 < held && keys[child] < keys[child + 1]) child++;
                  if (keys[pos] >= keys[child]) begin
                     moving = 1'b0;
                  end else begin
                     swap_slots(pos, child);
                     pos = child;
                  end
               end
            end
         end else begin
            // Not below the root, ties included: the new row is dropped.
            result.was_discarded     = 1'b1;
            result.discarded_key     = key;
            result.discarded_payload = payload;
         end
         result.held_count       = CNT_W'(held);
         result.largest_kept_key = keys[0];
         expected_outcomes = {expected_outcomes, result};
      endfunction

      // Compare one accepted result with the oldest expected outcome.
      function void check_outcome(outcome_type got);
         outcome_type want;
         if (expected_outcomes.size() == 0) begin
            $display("%0t: result with no row pending, held_count %0d",
                     $time, got.held_count);
            mismatches++;
            return;
         end
         want = expected_outcomes.pop_front();
         if (got.held_count !== want.held_count) begin
            $display("%0t: held_count expected %0d, got %0d",
                     $time, want.held_count, got.held_count);
            mismatches++;
         end
         if (got.was_discarded !== want.was_discarded) begin
            $display("%0t: was_discarded expected %0b, got %0b",
                     $time, want.was_discarded, got.was_discarded);
            mismatches++;
         end
         if (got.discarded_key !== want.discarded_key) begin
            $display("%0t: discarded_key expected %h, got %h",
                     $time, want.discarded_key, got.discarded_key);
            mismatches++;
         end
         if (got.discarded_payload !== want.discarded_payload) begin
            $display("%0t: discarded_payload expected %h, got %h",
                     $time, want.discarded_payload, got.discarded_payload);
            mismatches++;
         end
         if (got.largest_kept_key !== want.largest_kept_key) begin
            $display("%0t: largest_kept_key expected %h, got %h",
                     $time, want.largest_kept_key, got.largest_kept_key);
            mismatches++;
         end
      endfunction
   endclass

endpackage : top_k_check_pkg

module testbench;
   import tkh_pkg::*;
   import top_k_check_pkg::*;

   localparam int GAP_MAX       = 11;
   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_ROWS   = 650;
   localparam int CYCLE_LIMIT   = 400000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_write_enable = 1'b0;
   logic [CNT_W-1:0] csr_write_data = '0;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [KEY_W-1:0] req_sort_key = '0;
   logic [PAY_W-1:0] req_row_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [CNT_W-1:0] rsp_held_count;
   logic             rsp_was_discarded;
   logic [KEY_W-1:0] rsp_discarded_key;
   logic [PAY_W-1:0] rsp_discarded_payload;
   logic [KEY_W-1:0] rsp_largest_kept_key;

   kept_rows_scoreboard scoreboard = new();
   bit          calm;
   bit          hold_rsp;
   int unsigned rows_sent;
   int unsigned cycle_count;

   top_k_smallest_heap_core dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_sort_key          (req_sort_key),
      .req_row_payload       (req_row_payload),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_held_count        (rsp_held_count),
      .rsp_was_discarded     (rsp_was_discarded),
      .rsp_discarded_key     (rsp_discarded_key),
      .rsp_discarded_payload (rsp_discarded_payload),
      .rsp_largest_kept_key  (rsp_largest_kept_key)
   );

   // Clock with a period of two time units.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Reset is held only at the start of the run.
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // Run limit, far above the slowest correct run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Port monitor: every handshake feeds the scoreboard.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            scoreboard.check_outcome(outcome_type'({rsp_held_count, rsp_was_discarded,
               rsp_discarded_key, rsp_discarded_payload, rsp_largest_kept_key}));
         if (req_valid && req_ready)
            scoreboard.note_row(req_sort_key, req_row_payload);
      end
   end

   // Result side: a random stall before each item, or one long hold on request.
   initial begin : result_side
      int unsigned stall;
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            stall = calm ? 0 : $urandom_range(0, GAP_MAX);
            if (stall != 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready) && !hold_rsp);
      end
   end

   // Offer one row after a random gap and wait until it is taken.
   task automatic send_row(input logic [KEY_W-1:0] key, input logic [PAY_W-1:0] payload);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, GAP_MAX);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_sort_key    <= key;
      req_row_payload <= payload;
      do @(posedge clock); while (!(req_valid && req_ready));
      rows_sent++;
   endtask

   // Stop offering rows, wait for every outcome, then let the core settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Keep count writes happen only with the core idle.
   task automatic write_keep(input logic [CNT_W-1:0] value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      scoreboard.set_keep(value);
   endtask

   // Mostly keys within a span, so ties and deep sifts are common; extremes now and then.
   function automatic logic [KEY_W-1:0] draw_key(input logic [KEY_W-1:0] span_mask);
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return '1;
         default: return $urandom & span_mask;
      endcase
   endfunction

   // One random phase at a given keep count; optionally squeezes the result side.
   task automatic run_phase(input logic [CNT_W-1:0] keep, input int unsigned rows,
                            input bit squeeze);
      logic [KEY_W-1:0] span_mask;
      write_keep(keep);
      span_mask = {KEY_W{1'b1}} >> $urandom_range(0, KEY_W - 2);
      calm = squeeze || ($urandom_range(0, 3) == 0);
      if (squeeze) hold_rsp = 1'b1;
      repeat (rows) send_row(draw_key(span_mask), {$urandom, $urandom});
   endtask

   initial begin : stimulus
      int unsigned      rows;
      logic [CNT_W-1:0] keep;
      while (reset) @(posedge clock);

      // Fill a heap of four with extreme keys, then replace the root.
      write_keep(7'd4);
      send_row(32'd5, '0);
      send_row('1, '1);
      send_row('0, 64'h0123_4567_89AB_CDEF);
      send_row(32'd7, 64'hFEDC_BA98_7654_3210);
      send_row(32'd3, 64'h5555_5555_5555_5555);
      // A tie with the root and a larger key are both dropped.
      send_row(32'd7, 64'hAAAA_AAAA_AAAA_AAAA);
      send_row('1, '1);
      // Keep count lowered below the held count: the heap counts as full.
      write_keep(7'd2);
      send_row(32'd1, 64'h0000_0000_FFFF_FFFF);
      send_row(32'd100, 64'hFFFF_FFFF_0000_0000);
      // Keep count zero behaves as one.
      write_keep(7'd0);
      send_row('0, 64'h1);
      send_row(32'd5, 64'h2);
      // Keep count raised while full: filling resumes.
      write_keep(7'd10);
      send_row(32'd2, '0);
      send_row('1, '1);

      // Random part: fill gradually, saturate, squeeze, then mixed settings.
      rows_sent = 0;
      run_phase(CNT_W'($urandom_range(11, 40)), 40, 1'b0);
      run_phase(7'd127, 80, 1'b0);
      run_phase(CNT_W'($urandom_range(1, 64)), 24, 1'b1);
      while (rows_sent < RANDOM_ROWS) begin
         case ($urandom_range(0, 7))
            0:       keep = 7'd0;
            1:       keep = 7'd1;
            2:       keep = 7'd64;
            3:       keep = 7'd127;
            4:       keep = CNT_W'($urandom_range(65, 126));
            default: keep = CNT_W'($urandom_range(1, 64));
         endcase
         rows = $urandom_range(15, 60);
         run_phase(keep, rows, 1'b0);
      end

      // Wait for the last outcomes and give the verdict.
      drain();
      if (scoreboard.mismatches == 0 && scoreboard.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule : testbench
